// ===== rtl/core/cdn_pkg.sv =====
package cdn_pkg;

  localparam int unsigned DAY_W   = 13;
  localparam int unsigned MON_W   = 8;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MREG_W  = 9;
  localparam int unsigned YREG_W  = 16;
  localparam int unsigned DOUT_W  = 5;
  localparam int unsigned MOUT_W  = 4;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [MOUT_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MOUT_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MOUT_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MOUT_W-1:0] MONTH_DEC = 4'd12;

  localparam logic signed [YREG_W-1:0] YEAR_MIN = 16'sd1;
  localparam logic signed [YREG_W-1:0] YEAR_MAX = 16'sd9999;

  localparam logic [PADDR_W-1:0] REG_MONTH_ZERO_BASED = 3'd0;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_FOLD_DN,
    OP_FOLD_UP,
    OP_DAY_OVER,
    OP_DAY_UNDER,
    OP_CLAMP
  } cdn_op_t;

  typedef struct packed {
    logic m_hi;
    logic m_lo;
    logic d_hi;
    logic d_lo;
  } cdn_stat_t;

  function automatic logic [DOUT_W-1:0] days_in(input logic [MOUT_W-1:0] m,
                                                input logic [1:0] ylo);
    logic [DOUT_W-1:0] len;
    case (m)
      4'd2:                  len = (ylo == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:               len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] dow_offset(input logic [MOUT_W-1:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/core/cdn_cfg.sv =====
module cdn_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdn_pkg::PADDR_W-1:0] paddr,
  input  logic [cdn_pkg::PDATA_W-1:0] pwdata,
  output logic [cdn_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic                        month_zero_based
);
  import cdn_pkg::*;

  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = ({paddr[PADDR_W-1], 2'b00} == REG_MONTH_ZERO_BASED);

  always_ff @(posedge clk) begin
    if (rst) begin
      month_zero_based <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      month_zero_based <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {{(PDATA_W-1){1'b0}}, month_zero_based} : '0;

endmodule

// ===== rtl/core/cdn_dpath.sv =====
module cdn_dpath (
  input  logic                              clk,
  input  cdn_pkg::cdn_op_t                  op,
  input  logic                              month_zero_based,
  input  logic signed [cdn_pkg::DAY_W-1:0]  day_in,
  input  logic signed [cdn_pkg::MON_W-1:0]  month_in,
  input  logic [cdn_pkg::YEAR_W-1:0]        year_in,
  output cdn_pkg::cdn_stat_t                stat,
  output logic [cdn_pkg::DOUT_W-1:0]        day_out,
  output logic [cdn_pkg::MOUT_W-1:0]        month_out,
  output logic [cdn_pkg::YEAR_W-1:0]        year_out,
  output logic                              was_adjusted,
  output logic                              year_out_of_range
);
  import cdn_pkg::*;

  logic signed [DAY_W-1:0]  d;
  logic signed [MREG_W-1:0] m;
  logic signed [YREG_W-1:0] y;
  logic                     adj;
  logic                     oor;

  logic [DOUT_W-1:0]        len_cur;
  logic [MOUT_W-1:0]        m_prev;
  logic signed [YREG_W-1:0] y_prev;
  logic [DOUT_W-1:0]        len_prev;
  logic                     y_lo;
  logic                     y_hi;
  logic signed [YREG_W-1:0] y_clamp;
  logic [DOUT_W-1:0]        len_clamp;

  // shared step unit: one month or one fold per cycle
  always_comb begin
    len_cur   = days_in(m[MOUT_W-1:0], y[1:0]);
    m_prev    = (m[MOUT_W-1:0] == MONTH_JAN) ? MONTH_DEC : m[MOUT_W-1:0] - 4'd1;
    y_prev    = (m[MOUT_W-1:0] == MONTH_JAN) ? y - 16'sd1 : y;
    len_prev  = days_in(m_prev, y_prev[1:0]);
    y_lo      = (y < YEAR_MIN);
    y_hi      = (y > YEAR_MAX);
    y_clamp   = y_lo ? YEAR_MIN : (y_hi ? YEAR_MAX : y);
    len_clamp = days_in(m[MOUT_W-1:0], y_clamp[1:0]);
    stat.m_hi = (m > 9'sd12);
    stat.m_lo = (m < 9'sd1);
    stat.d_hi = (d > $signed({{(DAY_W-DOUT_W){1'b0}}, len_cur}));
    stat.d_lo = (d < 13'sd1);
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        d   <= day_in;
        m   <= MREG_W'(month_in) + $signed({{(MREG_W-1){1'b0}}, month_zero_based});
        y   <= $signed({{(YREG_W-YEAR_W){1'b0}}, year_in});
        adj <= 1'b0;
        oor <= 1'b0;
      end
      OP_FOLD_DN: begin
        m   <= m - 9'sd12;
        y   <= y + 16'sd1;
        adj <= 1'b1;
      end
      OP_FOLD_UP: begin
        m   <= m + 9'sd12;
        y   <= y - 16'sd1;
        adj <= 1'b1;
      end
      OP_DAY_OVER: begin
        d   <= d - $signed({{(DAY_W-DOUT_W){1'b0}}, len_cur});
        adj <= 1'b1;
        if (m[MOUT_W-1:0] == MONTH_DEC) begin
          m <= $signed({{(MREG_W-MOUT_W){1'b0}}, MONTH_JAN});
          y <= y + 16'sd1;
        end else begin
          m <= m + 9'sd1;
        end
      end
      OP_DAY_UNDER: begin
        d   <= d + $signed({{(DAY_W-DOUT_W){1'b0}}, len_prev});
        m   <= $signed({{(MREG_W-MOUT_W){1'b0}}, m_prev});
        y   <= y_prev;
        adj <= 1'b1;
      end
      OP_CLAMP: begin
        y   <= y_clamp;
        oor <= y_lo || y_hi;
        if (y_lo || y_hi) begin
          adj <= 1'b1;
          if (d > $signed({{(DAY_W-DOUT_W){1'b0}}, len_clamp})) begin
            d <= $signed({{(DAY_W-DOUT_W){1'b0}}, len_clamp});
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign day_out           = d[DOUT_W-1:0];
  assign month_out         = m[MOUT_W-1:0];
  assign year_out          = y[YEAR_W-1:0];
  assign was_adjusted      = adj;
  assign year_out_of_range = oor;

endmodule

// ===== rtl/core/cdn_wday.sv =====
module cdn_wday (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [cdn_pkg::YEAR_W-1:0]  year,
  input  logic [cdn_pkg::MOUT_W-1:0]  month,
  input  logic [cdn_pkg::DOUT_W-1:0]  day,
  output logic                        out_valid,
  output logic [cdn_pkg::WDAY_W-1:0]  weekday
);
  import cdn_pkg::*;

  localparam int unsigned P_W   = YEAR_W + 13;
  localparam int unsigned S_W   = 14;
  localparam int unsigned Q_W   = 7;
  localparam int unsigned PR_W  = S_W + 14;
  localparam int unsigned Q7_W  = PR_W - 16;

  logic [3:0]              vpipe;

  logic [YEAR_W-1:0]       yy1;
  logic [P_W-1:0]          p1;
  logic [MOUT_W-1:0]       m1;
  logic [DOUT_W-1:0]       d1;

  logic [S_W-1:0]          s2;
  logic [S_W-1:0]          s3;
  logic [PR_W-1:0]         pr3;

  logic [YEAR_W-1:0]       yy0;
  logic [Q_W-1:0]          q100;
  logic [S_W-1:0]          s_sum;
  logic [Q7_W-1:0]         q7;
  logic [S_W-1:0]          r_full;
  logic [3:0]              r;
  logic [WDAY_W-1:0]       w;

  always_comb begin
    yy0    = year - YEAR_W'(month < MONTH_MAR);
    // floor(x/100) = (x*5243) >> 19 for x below 43699
    q100   = p1[19 +: Q_W];
    s_sum  = S_W'(yy1) + S_W'(yy1 >> 2) - S_W'(q100) + S_W'(q100 >> 2)
           + S_W'(dow_offset(m1)) + S_W'(d1);
    // 9362/65536 sits just under 1/7: quotient is exact or one low
    q7     = pr3[16 +: Q7_W];
    r_full = s3 - S_W'({q7, 3'b000} - {3'b000, q7});
    r      = r_full[3:0];
    w      = (r >= 4'd7) ? WDAY_W'(r - 4'd6) : WDAY_W'(r + 4'd1);
  end

  always_ff @(posedge clk) begin
    yy1 <= yy0;
    p1  <= P_W'(yy0) * P_W'(13'd5243);
    m1  <= month;
    d1  <= day;
    s2  <= s_sum;
    s3  <= s2;
    pr3 <= PR_W'(s2) * PR_W'(14'd9362);
    weekday <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[2:0], in_valid};
    end
  end

  assign out_valid = vpipe[3];

endmodule

// ===== rtl/core/calendar_date_normalizer.sv =====
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+-------------------------------
// request  | day_in, month_in, year_in                    | start high while busy low
// result   | day_out, month_out, year_out, was_adjusted,  | done high for one cycle,
//          | weekday, year_out_of_range                   | no backpressure
// config   | psel, penable, pwrite, paddr, pwdata, prdata | APB, pready tied high
//
// One request at a time; done pulses once the request has gone through k month folds
// (at most 11), j day steps of one month each (at most 135), the clamp and the weekday.
// The shared step unit moves the day by one month per cycle; the weekday unit comes last.
// busy is high from the accepting edge until the done cycle, when a new request
// may already be taken. Synchronous reset clears the sequencer and the config bit.
module calendar_date_normalizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [cdn_pkg::DAY_W-1:0]  day_in,
  input  logic signed [cdn_pkg::MON_W-1:0]  month_in,
  input  logic [cdn_pkg::YEAR_W-1:0]        year_in,
  output logic                              done,
  output logic [cdn_pkg::DOUT_W-1:0]        day_out,
  output logic [cdn_pkg::MOUT_W-1:0]        month_out,
  output logic [cdn_pkg::YEAR_W-1:0]        year_out,
  output logic                              was_adjusted,
  output logic [cdn_pkg::WDAY_W-1:0]        weekday,
  output logic                              year_out_of_range,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cdn_pkg::PADDR_W-1:0]       paddr,
  input  logic [cdn_pkg::PDATA_W-1:0]       pwdata,
  output logic [cdn_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import cdn_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FOLD   = 6'b000010,
    ST_DAY    = 6'b000100,
    ST_CLAMP  = 6'b001000,
    ST_WSTART = 6'b010000,
    ST_WWAIT  = 6'b100000
  } state_t;

  state_t    state;
  state_t    state_next;
  cdn_op_t   op;
  cdn_stat_t stat;
  logic      month_zero_based;
  logic      w_valid;

  cdn_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .month_zero_based (month_zero_based)
  );

  cdn_dpath u_dpath (
    .clk               (clk),
    .op                (op),
    .month_zero_based  (month_zero_based),
    .day_in            (day_in),
    .month_in          (month_in),
    .year_in           (year_in),
    .stat              (stat),
    .day_out           (day_out),
    .month_out         (month_out),
    .year_out          (year_out),
    .was_adjusted      (was_adjusted),
    .year_out_of_range (year_out_of_range)
  );

  cdn_wday u_wday (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (state == ST_WSTART),
    .year      (year_out),
    .month     (month_out),
    .day       (day_out),
    .out_valid (w_valid),
    .weekday   (weekday)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op         = OP_LOAD;
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (stat.m_hi) begin
          op = OP_FOLD_DN;
        end else if (stat.m_lo) begin
          op = OP_FOLD_UP;
        end else begin
          state_next = ST_DAY;
        end
      end
      ST_DAY: begin
        if (stat.d_hi) begin
          op = OP_DAY_OVER;
        end else if (stat.d_lo) begin
          op = OP_DAY_UNDER;
        end else begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        op         = OP_CLAMP;
        state_next = ST_WSTART;
      end
      ST_WSTART: begin
        state_next = ST_WWAIT;
      end
      ST_WWAIT: begin
        if (w_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_WWAIT) && w_valid;
    end
  end

`ifndef ASSERT_OFF
  a_done_from_wait: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(state == ST_WWAIT))
    else $error("done without finished weekday");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("request not taken");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1)
             && (weekday >= 3'd1) && (weekday <= 3'd7))
    else $error("result field out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (year_out >= 14'd1) && (year_out <= 14'd9999))
    else $error("year not clamped");
`endif

endmodule
